@@ design/i2cm_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
// Used by the core, the output buffer, the top level and the checker.
package i2cm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int LIM_W       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [15:0] BIT_PHASE_RESET = 16'd10;
  localparam logic [15:0] COND_RESET      = 16'd1000;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_PHASE = 2'd0,
    REG_COND      = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_S1, PH_S2, PH_S3, PH_Q0, PH_Q1, PH_Q2, PH_Q3, PH_P1, PH_P2, PH_P3
  } phase_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] slave_address;
    logic       read_not_write;
    logic [7:0] data_byte;
    logic       ack_after_read;
    logic       last_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       command_rejected;
    logic       byte_done;
    logic [7:0] read_data;
    logic       ack_received;
    logic       transaction_done;
    logic       transaction_ok;
  } result_t;

endpackage

@@ design/i2c_master_byte_engine.sv @@
// I2C master byte engine, top level. The result of an accepted item
// is registered in the result buffer. Throughput: one item per cycle
// while in_stall_o is low; the sequencer updates its whole state for
// each item, and a two-entry buffer accepts input while a result waits.
// Reset (async, active low) idles the sequencer, clears its line drive
// state and loads bit_phase_ticks = 10 and condition_ticks = 1000.
module i2c_master_byte_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [6:0] slave_address_i,
  input  logic       read_not_write_i,
  input  logic [7:0] data_byte_i,
  input  logic       ack_after_read_i,
  input  logic       last_byte_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_drive_low_o,
  output logic       sda_drive_low_o,
  output logic       busy_res_o,
  output logic       command_rejected_o,
  output logic       byte_done_o,
  output logic [7:0] read_data_o,
  output logic       ack_received_o,
  output logic       transaction_done_o,
  output logic       transaction_ok_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import i2cm_pkg::*;

  item_t   item;
  result_t core_res, out_res;
  logic    accept, buf_full;

  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !buf_full;
  assign cfg_ready_o = 1'b1;

  assign item.opcode         = opcode_i;
  assign item.slave_address  = slave_address_i;
  assign item.read_not_write = read_not_write_i;
  assign item.data_byte      = data_byte_i;
  assign item.ack_after_read = ack_after_read_i;
  assign item.last_byte      = last_byte_i;
  assign item.sda_in         = sda_in_i;

  i2cm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (core_res)
  );

  i2cm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (core_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign scl_drive_low_o    = out_res.scl_drive_low;
  assign sda_drive_low_o    = out_res.sda_drive_low;
  assign busy_res_o         = out_res.busy_res;
  assign command_rejected_o = out_res.command_rejected;
  assign byte_done_o        = out_res.byte_done;
  assign read_data_o        = out_res.read_data;
  assign ack_received_o     = out_res.ack_received;
  assign transaction_done_o = out_res.transaction_done;
  assign transaction_ok_o   = out_res.transaction_ok;

endmodule

@@ design/i2cm_core.sv @@
// Bus sequencer of the I2C master: phase state, tick counter, shift register.
// Computes one result per accepted item; depends on i2cm_pkg.
module i2cm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  i2cm_pkg::item_t item_i,
  input  logic            cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  output i2cm_pkg::result_t result_o
);
  import i2cm_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [3:0]             bidx_q, bidx_d;
  logic [7:0]             shift_q, shift_d;
  logic                   reading_q, reading_d;
  logic                   sack_q, sack_d;
  logic                   stop_q, stop_d;
  logic                   nack_q, nack_d;
  logic [1:0]             line_q, line_d;
  logic [15:0]            bit_phase_q, cond_q;

  logic       enter;
  logic       cond_phase;
  logic [15:0] len_sel, lim_raw;
  logic [LIM_W-1:0] lim_ext, lim;

  // Line drive pattern of a phase; bit 0 pulls SCL low, bit 1 pulls SDA low.
  function automatic logic [1:0] phase_drives(phase_e ph, logic [3:0] bidx, logic [7:0] sh,
                                              logic rd, logic sa, logic [1:0] keep);
    logic scl;
    logic sda;
    logic [1:0] res;
    scl = 1'b0;
    sda = 1'b0;
    res = keep;
    unique case (ph)
      PH_S1, PH_P3: res = 2'b00;
      PH_S2, PH_P2: res = 2'b10;
      PH_S3, PH_P1: res = 2'b11;
      PH_Q0, PH_Q1, PH_Q2, PH_Q3: begin
        scl = (ph == PH_Q0) || (ph == PH_Q3);
        if (bidx < 4'd8) begin
          sda = rd ? 1'b0 : ~sh[7];
        end else begin
          sda = rd ? sa : 1'b0;
        end
        res = {sda, scl};
      end
      default: res = keep;
    endcase
    return res;
  endfunction

  always_comb begin
    cond_phase = (phase_q == PH_S1) || (phase_q == PH_S2) || (phase_q == PH_S3) ||
                 (phase_q == PH_P1) || (phase_q == PH_P2) || (phase_q == PH_P3);
    len_sel = cond_phase ? cond_q : bit_phase_q;
    lim_raw = (len_sel == 16'd0) ? 16'd0 : len_sel - 16'd1;
    lim_ext = LIM_W'(lim_raw);
    lim     = (lim_ext > LIM_W'(CNT_MAX)) ? LIM_W'(CNT_MAX) : lim_ext;
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bidx_d    = bidx_q;
    shift_d   = shift_q;
    reading_d = reading_q;
    sack_d    = sack_q;
    stop_d    = stop_q;
    nack_d    = nack_q;
    line_d    = line_q;
    enter     = 1'b0;
    result_o  = '0;

    if (accept_i) begin
      if (item_i.opcode != OP_TICK) begin
        if (phase_q != PH_IDLE) begin
          result_o.command_rejected = 1'b1;
        end else begin
          stop_d    = item_i.last_byte;
          bidx_d    = 4'd0;
          sack_d    = 1'b0;
          reading_d = 1'b0;
          enter     = 1'b1;
          unique case (item_i.opcode)
            OP_START: begin
              shift_d = {item_i.slave_address, item_i.read_not_write};
              phase_d = PH_S1;
            end
            OP_WRITE: begin
              shift_d = item_i.data_byte;
              phase_d = PH_Q0;
            end
            default: begin
              shift_d   = 8'd0;
              reading_d = 1'b1;
              sack_d    = item_i.ack_after_read;
              phase_d   = PH_Q0;
            end
          endcase
        end
      end else if (phase_q != PH_IDLE) begin
        if (LIM_W'(tick_q) < lim) begin
          tick_d = tick_q + 1'b1;
        end else begin
          unique case (phase_q)
            PH_S1: begin phase_d = PH_S2; enter = 1'b1; end
            PH_S2: begin phase_d = PH_S3; enter = 1'b1; end
            PH_S3: begin phase_d = PH_Q0; enter = 1'b1; end
            PH_Q0: begin phase_d = PH_Q1; enter = 1'b1; end
            PH_Q1: begin
              if (bidx_q < 4'd8) begin
                if (reading_q) begin
                  shift_d = {shift_q[6:0], item_i.sda_in};
                end
              end else if (!reading_q) begin
                // The acknowledge level is kept for the result of this byte.
                shift_d = {7'd0, item_i.sda_in};
                if (item_i.sda_in) begin
                  nack_d = 1'b1;
                end
              end
              phase_d = PH_Q2;
              enter   = 1'b1;
            end
            PH_Q2: begin phase_d = PH_Q3; enter = 1'b1; end
            PH_Q3: begin
              if (bidx_q < 4'd8) begin
                if (!reading_q) begin
                  shift_d = {shift_q[6:0], 1'b0};
                end
                bidx_d  = bidx_q + 4'd1;
                phase_d = PH_Q0;
                enter   = 1'b1;
              end else begin
                result_o.byte_done = 1'b1;
                if (reading_q) begin
                  result_o.read_data = shift_q;
                end else begin
                  result_o.ack_received = ~shift_q[0];
                end
                bidx_d = 4'd0;
                if (stop_q) begin
                  phase_d = PH_P1;
                  enter   = 1'b1;
                end else begin
                  // Hold the bus between bytes: SCL low, SDA released.
                  phase_d = PH_IDLE;
                  tick_d  = '0;
                  line_d  = 2'b01;
                end
              end
            end
            PH_P1: begin phase_d = PH_P2; enter = 1'b1; end
            PH_P2: begin phase_d = PH_P3; enter = 1'b1; end
            default: begin
              result_o.transaction_done = 1'b1;
              result_o.transaction_ok   = ~nack_q;
              nack_d  = 1'b0;
              stop_d  = 1'b0;
              phase_d = PH_IDLE;
              tick_d  = '0;
              line_d  = 2'b00;
            end
          endcase
        end
      end
    end

    if (enter) begin
      tick_d = '0;
      line_d = phase_drives(phase_d, bidx_d, shift_d, reading_d, sack_d, line_q);
    end

    result_o.scl_drive_low = line_d[0];
    result_o.sda_drive_low = line_d[1];
    result_o.busy_res      = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bidx_q    <= 4'd0;
      shift_q   <= 8'd0;
      reading_q <= 1'b0;
      sack_q    <= 1'b0;
      stop_q    <= 1'b0;
      nack_q    <= 1'b0;
      line_q    <= 2'b00;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bidx_q    <= bidx_d;
      shift_q   <= shift_d;
      reading_q <= reading_d;
      sack_q    <= sack_d;
      stop_q    <= stop_d;
      nack_q    <= nack_d;
      line_q    <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_phase_q <= BIT_PHASE_RESET;
      cond_q      <= COND_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_BIT_PHASE) begin
        bit_phase_q <= cfg_data_i;
      end else if (cfg_index_i == REG_COND) begin
        cond_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ design/i2cm_out_buf.sv @@
// Two-entry result register with a skid stage, so the input side keeps
// accepting while one result waits downstream. Depends on i2cm_pkg.
module i2cm_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cm_pkg::result_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2cm_pkg::result_t out_data_o
);
  import i2cm_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

endmodule

@@ design/i2cm_checker.sv @@
// Port-level checker for the I2C master byte engine and its bind statement.
// Depends on i2cm_pkg and the top level's ports.
module i2cm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       busy_res_o,
  input logic       command_rejected_o,
  input logic       byte_done_o,
  input logic [7:0] read_data_o,
  input logic       ack_received_o,
  input logic       transaction_done_o,
  input logic       transaction_ok_o
);
  import i2cm_pkg::*;

  // A stop ends the transaction, so the block cannot still be busy.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transaction_done_o |-> !busy_res_o)
    else $error("transaction_done while still busy");

  // A rejected command can only happen while a command is in progress.
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_rejected_o |-> busy_res_o && !byte_done_o)
    else $error("command rejected while idle");

  // Byte status fields are only reported together with byte_done.
  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_done_o |-> !ack_received_o && (read_data_o == 8'd0))
    else $error("byte status without byte_done");

  a_ok_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transaction_ok_o |-> transaction_done_o)
    else $error("transaction_ok without transaction_done");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .busy_res_o         (busy_res_o),
  .command_rejected_o (command_rejected_o),
  .byte_done_o        (byte_done_o),
  .read_data_o        (read_data_o),
  .ack_received_o     (ack_received_o),
  .transaction_done_o (transaction_done_o),
  .transaction_ok_o   (transaction_ok_o)
);

@@ dv/tb_i2c_master_byte_engine.sv @@
// Self-checking testbench for the I2C master byte engine.
// Depends on design/i2cm_pkg.sv and design/i2c_master_byte_engine.sv; a cycle-level
// predictor of the bus sequencer checks every result transfer in order.
module tb_i2c_master_byte_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 200;
  localparam int MAX_REPORTS = 10;

  typedef enum {SLAVE_ACKS, SLAVE_NACKS, SLAVE_RANDOM} slave_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] opcode_i;
  logic [6:0] slave_address_i;
  logic       read_not_write_i;
  logic [7:0] data_byte_i;
  logic       ack_after_read_i;
  logic       last_byte_i;
  logic       sda_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       scl_drive_low_o;
  logic       sda_drive_low_o;
  logic       busy_res_o;
  logic       command_rejected_o;
  logic       byte_done_o;
  logic [7:0] read_data_o;
  logic       ack_received_o;
  logic       transaction_done_o;
  logic       transaction_ok_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  i2c_master_byte_engine u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .slave_address_i    (slave_address_i),
    .read_not_write_i   (read_not_write_i),
    .data_byte_i        (data_byte_i),
    .ack_after_read_i   (ack_after_read_i),
    .last_byte_i        (last_byte_i),
    .sda_in_i           (sda_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .scl_drive_low_o    (scl_drive_low_o),
    .sda_drive_low_o    (sda_drive_low_o),
    .busy_res_o         (busy_res_o),
    .command_rejected_o (command_rejected_o),
    .byte_done_o        (byte_done_o),
    .read_data_o        (read_data_o),
    .ack_received_o     (ack_received_o),
    .transaction_done_o (transaction_done_o),
    .transaction_ok_o   (transaction_ok_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted sequencer state and register copies, at their reset values.
  phase_e      bus_phase      = PH_IDLE;
  int unsigned phase_ticks    = 0;
  int unsigned bit_pos        = 0;
  logic [7:0]  shreg          = '0;
  logic        rd_mode        = 1'b0;
  logic        master_ack     = 1'b0;
  logic        stop_armed     = 1'b0;
  logic        nack_flag      = 1'b0;
  logic        scl_low        = 1'b0;
  logic        sda_low        = 1'b0;
  logic [15:0] cfg_bit_ticks  = BIT_PHASE_RESET;
  logic [15:0] cfg_cond_ticks = COND_RESET;

  result_t bus_results_due[$];
  int      items_sent    = 0;
  int      results_seen  = 0;
  int      failures      = 0;
  int      cycles        = 0;
  bit      idle_on       = 1'b1;
  bit      hold_off_req  = 1'b0;
  int      tx_calm       = 0;
  int      rx_calm       = 0;
  int      rx_stall_left = 0;
  int      hold_count;

  function automatic int unsigned phase_limit(input logic [15:0] len);
    int unsigned lim;
    lim = (len == 0) ? 0 : len - 1;
    if (lim > CNT_MAX) lim = CNT_MAX;
    return lim;
  endfunction

  function automatic void drive_lines();
    logic scl;
    logic sda;
    scl = 1'b0;
    sda = 1'b0;
    case (bus_phase)
      PH_S1, PH_P3: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_S2, PH_P2: sda = 1'b1;
      PH_S3, PH_P1: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      PH_Q0, PH_Q1, PH_Q2, PH_Q3: begin
        scl = (bus_phase == PH_Q0 || bus_phase == PH_Q3);
        if (bit_pos < 8) sda = rd_mode ? 1'b0 : ~shreg[7];
        else sda = rd_mode ? master_ack : 1'b0;
      end
      default: return;
    endcase
    scl_low = scl;
    sda_low = sda;
  endfunction

  function automatic void enter_phase(input phase_e p);
    bus_phase   = p;
    phase_ticks = 0;
    drive_lines();
  endfunction

  // Advances the predicted sequencer by one accepted item and returns the
  // result transfer that item must produce.
  function automatic result_t next_bus_result(input item_t it);
    result_t     r;
    int unsigned lim;
    logic        in_condition;
    r = '0;
    if (it.opcode != OP_TICK) begin
      if (bus_phase != PH_IDLE) begin
        r.command_rejected = 1'b1;
      end else begin
        stop_armed = it.last_byte;
        bit_pos    = 0;
        master_ack = 1'b0;
        rd_mode    = 1'b0;
        case (it.opcode)
          OP_START: begin
            shreg = {it.slave_address, it.read_not_write};
            enter_phase(PH_S1);
          end
          OP_WRITE: begin
            shreg = it.data_byte;
            enter_phase(PH_Q0);
          end
          default: begin
            shreg      = '0;
            rd_mode    = 1'b1;
            master_ack = it.ack_after_read;
            enter_phase(PH_Q0);
          end
        endcase
      end
    end else if (bus_phase != PH_IDLE) begin
      in_condition = bus_phase inside {PH_S1, PH_S2, PH_S3, PH_P1, PH_P2, PH_P3};
      lim = phase_limit(in_condition ? cfg_cond_ticks : cfg_bit_ticks);
      if (phase_ticks < lim) begin
        phase_ticks = (phase_ticks + 1) & CNT_MAX;
      end else begin
        case (bus_phase)
          PH_S1: enter_phase(PH_S2);
          PH_S2: enter_phase(PH_S3);
          PH_S3: enter_phase(PH_Q0);
          PH_Q0: enter_phase(PH_Q1);
          PH_Q1: begin
            if (bit_pos < 8) begin
              if (rd_mode) shreg = {shreg[6:0], it.sda_in};
            end else if (!rd_mode) begin
              // The acknowledge level is held in the shift register.
              shreg = {7'd0, it.sda_in};
              if (it.sda_in) nack_flag = 1'b1;
            end
            enter_phase(PH_Q2);
          end
          PH_Q2: enter_phase(PH_Q3);
          PH_Q3: begin
            if (bit_pos < 8) begin
              if (!rd_mode) shreg = shreg << 1;
              bit_pos++;
              enter_phase(PH_Q0);
            end else begin
              r.byte_done = 1'b1;
              if (rd_mode) r.read_data = shreg;
              else r.ack_received = ~shreg[0];
              bit_pos = 0;
              if (stop_armed) begin
                enter_phase(PH_P1);
              end else begin
                // Between bytes the bus is held with SCL low.
                bus_phase   = PH_IDLE;
                phase_ticks = 0;
                scl_low     = 1'b1;
                sda_low     = 1'b0;
              end
            end
          end
          PH_P1: enter_phase(PH_P2);
          PH_P2: enter_phase(PH_P3);
          default: begin
            r.transaction_done = 1'b1;
            r.transaction_ok   = ~nack_flag;
            nack_flag   = 1'b0;
            stop_armed  = 1'b0;
            bus_phase   = PH_IDLE;
            phase_ticks = 0;
            scl_low     = 1'b0;
            sda_low     = 1'b0;
          end
        endcase
      end
    end
    r.scl_drive_low = scl_low;
    r.sda_drive_low = sda_low;
    r.busy_res      = (bus_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%s mismatch on result %0d: expected %0h, got %0h",
                 name, results_seen, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_results_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result transfer %0d arrived with nothing expected", results_seen);
      end else begin
        check_field("scl_drive_low", 8'(bus_results_due[0].scl_drive_low),
                    8'(scl_drive_low_o));
        check_field("sda_drive_low", 8'(bus_results_due[0].sda_drive_low),
                    8'(sda_drive_low_o));
        check_field("busy_res", 8'(bus_results_due[0].busy_res), 8'(busy_res_o));
        check_field("command_rejected", 8'(bus_results_due[0].command_rejected),
                    8'(command_rejected_o));
        check_field("byte_done", 8'(bus_results_due[0].byte_done), 8'(byte_done_o));
        check_field("read_data", bus_results_due[0].read_data, read_data_o);
        check_field("ack_received", 8'(bus_results_due[0].ack_received),
                    8'(ack_received_o));
        check_field("transaction_done", 8'(bus_results_due[0].transaction_done),
                    8'(transaction_done_o));
        check_field("transaction_ok", 8'(bus_results_due[0].transaction_ok),
                    8'(transaction_ok_o));
        void'(bus_results_due.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_master_byte_engine verification failed");
      $finish;
    end
  end

  // Receiver side: random stall bursts, calm stretches, and one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off_req = 1'b0;
      end else if (idle_on && rx_calm > 0) begin
        rx_calm--;
        out_stall_i <= 1'b0;
      end else if (idle_on && rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rx_stall_left = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        if (idle_on && $urandom_range(0, 40) == 0) rx_calm = $urandom_range(20, 60);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(input item_t it);
    int gap;
    in_valid_i       <= 1'b1;
    opcode_i         <= it.opcode;
    slave_address_i  <= it.slave_address;
    read_not_write_i <= it.read_not_write;
    data_byte_i      <= it.data_byte;
    ack_after_read_i <= it.ack_after_read;
    last_byte_i      <= it.last_byte;
    sda_in_i         <= it.sda_in;
    do @(posedge clk_i); while (in_stall_o);
    bus_results_due.push_back(next_bus_result(it));
    items_sent++;
    if (tx_calm > 0) begin
      tx_calm--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else if (idle_on && $urandom_range(0, 30) == 0) begin
      tx_calm = $urandom_range(20, 60);
    end
  endtask

  // Register writes happen only once every result transfer has come back.
  task automatic write_register(input cfg_reg_e idx, input logic [15:0] value);
    in_valid_i <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_BIT_PHASE) cfg_bit_ticks = value;
    else cfg_cond_ticks = value;
  endtask

  function automatic item_t random_item();
    logic [31:0] raw;
    raw = $urandom;
    return item_t'(raw[$bits(item_t)-1:0]);
  endfunction

  function automatic item_t tick_item(input logic sda);
    item_t it;
    it        = random_item();
    it.opcode = OP_TICK;
    it.sda_in = sda;
    return it;
  endfunction

  function automatic item_t command_item(input opcode_e op, input logic [6:0] addr,
                                         input logic rnw, input logic [7:0] data,
                                         input logic ack, input logic last);
    item_t it;
    it                = random_item();
    it.opcode         = op;
    it.slave_address  = addr;
    it.read_not_write = rnw;
    it.data_byte      = data;
    it.ack_after_read = ack;
    it.last_byte      = last;
    return it;
  endfunction

  // Ticks the sequencer back to idle, playing the target on the acknowledge bit and
  // now and then offering a command that must be rejected.
  task automatic drive_to_idle(input slave_e slave);
    item_t it;
    while (bus_phase != PH_IDLE) begin
      it = random_item();
      if ($urandom_range(0, 24) != 0) begin
        it.opcode = OP_TICK;
        if (bus_phase == PH_Q1 && bit_pos == 8 && !rd_mode)
          it.sda_in = (slave == SLAVE_NACKS) ||
                      (slave == SLAVE_RANDOM && $urandom_range(0, 4) == 0);
      end else if (it.opcode == OP_TICK) begin
        it.opcode = OP_WRITE;
      end
      send_item(it);
    end
  endtask

  function automatic logic [15:0] pick_timing();
    if ($urandom_range(0, 7) == 0) return 16'($urandom_range(2, 3));
    return 16'($urandom_range(0, 1));
  endfunction

  task automatic random_transaction();
    int      nbytes;
    int      b;
    logic    rnw;
    logic    last;
    opcode_e op;
    if ($urandom_range(0, 9) == 0) begin
      // Noise: arbitrary items, which may start bytes with no start condition.
      repeat ($urandom_range(1, 8)) send_item(random_item());
      drive_to_idle(SLAVE_RANDOM);
      return;
    end
    rnw = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) != 0) begin
      send_item(command_item(OP_START, 7'($urandom_range(0, 127)), rnw,
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0));
      drive_to_idle(SLAVE_RANDOM);
    end
    nbytes = $urandom_range(1, 2);
    for (b = 1; b <= nbytes; b++) begin
      last = (b == nbytes) && ($urandom_range(0, 7) != 0);
      op   = (rnw ^ ($urandom_range(0, 9) == 0)) ? OP_READ : OP_WRITE;
      send_item(command_item(op, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), last));
      drive_to_idle(SLAVE_RANDOM);
      repeat ($urandom_range(0, 2)) send_item(tick_item(1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_reset_values();
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b0));
    send_item(command_item(OP_WRITE, 7'h55, 1'b1, 8'hA5, 1'b0, 1'b0));
    repeat (15) send_item(tick_item(1'($urandom_range(0, 1))));
    write_register(REG_BIT_PHASE, 16'd1);
    drive_to_idle(SLAVE_ACKS);
    // With the reset condition length, the first start step holds through these ticks.
    send_item(command_item(OP_START, 7'h2A, 1'b0, 8'h00, 1'b1, 1'b0));
    repeat (20) send_item(tick_item(1'($urandom_range(0, 1))));
    write_register(REG_COND, 16'd1);
    drive_to_idle(SLAVE_ACKS);
  endtask

  task automatic test_zero_lengths();
    write_register(REG_BIT_PHASE, 16'd0);
    write_register(REG_COND, 16'd0);
    send_item(command_item(OP_START, 7'h7F, 1'b0, 8'h00, 1'b0, 1'b0));
    drive_to_idle(SLAVE_ACKS);
    send_item(command_item(OP_WRITE, 7'h00, 1'b1, 8'hFF, 1'b1, 1'b1));
    drive_to_idle(SLAVE_NACKS);
    send_item(command_item(OP_READ, 7'h00, 1'b1, 8'hFF, 1'b0, 1'b1));
    drive_to_idle(SLAVE_RANDOM);
  endtask

  task automatic test_busy_rejects();
    write_register(REG_BIT_PHASE, 16'd1);
    write_register(REG_COND, 16'd2);
    send_item(command_item(OP_START, 7'h11, 1'b0, 8'h00, 1'b0, 1'b0));
    send_item(command_item(OP_START, 7'h22, 1'b1, 8'h33, 1'b1, 1'b1));
    send_item(command_item(OP_WRITE, 7'h22, 1'b1, 8'h44, 1'b1, 1'b1));
    send_item(command_item(OP_READ, 7'h22, 1'b1, 8'h55, 1'b1, 1'b1));
    drive_to_idle(SLAVE_ACKS);
    send_item(command_item(OP_WRITE, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1));
    send_item(command_item(OP_READ, 7'h7F, 1'b1, 8'hFF, 1'b1, 1'b0));
    drive_to_idle(SLAVE_ACKS);
  endtask

  task automatic test_repeated_start();
    write_register(REG_BIT_PHASE, 16'd1);
    write_register(REG_COND, 16'd1);
    // A missing acknowledge before the repeated start must still fail the transaction.
    send_item(command_item(OP_WRITE, 7'h3C, 1'b0, 8'h81, 1'b0, 1'b0));
    drive_to_idle(SLAVE_NACKS);
    send_item(tick_item(1'b1));
    send_item(command_item(OP_START, 7'h5A, 1'b0, 8'h00, 1'b0, 1'b0));
    drive_to_idle(SLAVE_ACKS);
    send_item(command_item(OP_WRITE, 7'h00, 1'b0, 8'h7E, 1'b0, 1'b1));
    drive_to_idle(SLAVE_ACKS);
    send_item(tick_item(1'b0));
  endtask

  task automatic test_register_extremes();
    write_register(REG_BIT_PHASE, 16'hFFFF);
    send_item(command_item(OP_WRITE, 7'h01, 1'b0, 8'hC3, 1'b0, 1'b0));
    repeat (10) send_item(tick_item(1'($urandom_range(0, 1))));
    write_register(REG_BIT_PHASE, 16'd1);
    drive_to_idle(SLAVE_ACKS);
    write_register(REG_COND, 16'hFFFF);
    send_item(command_item(OP_START, 7'h40, 1'b1, 8'h00, 1'b0, 1'b0));
    repeat (10) send_item(tick_item(1'($urandom_range(0, 1))));
    write_register(REG_COND, 16'd2);
    drive_to_idle(SLAVE_ACKS);
  endtask

  task automatic test_backpressure();
    write_register(REG_BIT_PHASE, 16'd1);
    write_register(REG_COND, 16'd1);
    hold_off_req = 1'b1;
    send_item(command_item(OP_START, 7'h68, 1'b0, 8'h00, 1'b0, 1'b0));
    repeat (20) send_item(tick_item(1'b0));
    drive_to_idle(SLAVE_ACKS);
    send_item(command_item(OP_WRITE, 7'h00, 1'b0, 8'h96, 1'b0, 1'b1));
    drive_to_idle(SLAVE_ACKS);
    while (hold_off_req) @(posedge clk_i);
  endtask

  task automatic test_random_traffic(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        write_register(REG_BIT_PHASE, pick_timing());
        write_register(REG_COND, pick_timing());
      end
      random_transaction();
    end
  endtask

  initial begin
    in_valid_i       = 1'b0;
    opcode_i         = OP_TICK;
    slave_address_i  = '0;
    read_not_write_i = 1'b0;
    data_byte_i      = '0;
    ack_after_read_i = 1'b0;
    last_byte_i      = 1'b0;
    sda_in_i         = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_BIT_PHASE;
    cfg_data_i       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_zero_lengths();
    test_busy_rejects();
    test_repeated_start();
    test_register_extremes();
    test_backpressure();
    test_random_traffic(60);
    // Final stretch runs with both sides streaming without gaps.
    idle_on = 1'b0;
    test_random_traffic(30);

    in_valid_i <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (failures == 0) begin
      $display("i2c_master_byte_engine verification clean");
    end else begin
      $display("i2c_master_byte_engine verification failed");
    end
    $finish;
  end

endmodule
